FILE: rtl/core/ducking_envelope_controller_core_assert.svh
// Assertion macros shared by the ducking envelope checkers
`ifndef DUCKING_ENVELOPE_CONTROLLER_CORE_ASSERT_SVH
`define DUCKING_ENVELOPE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define DED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define DED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ded_pkg.sv
// Types, codes and constants of the ducking envelope controller
package ded_pkg;

  localparam int TickW  = 8;
  localparam int TimeW  = 16;
  localparam int MsW    = 15;
  localparam int LevelW = 17;
  localparam int ReqW   = 16;
  localparam int FracW  = 16;
  localparam int QuotW  = TickW + FracW;
  localparam int DivCntW = $clog2(QuotW);
  localparam int CfgIdxW = 3;
  localparam int CfgW   = 17;

  localparam logic [LevelW-1:0] FullLevel = LevelW'(65536);
  localparam logic [TimeW-1:0]  TimeMax   = '1;

  // Reset values of the current times and the register defaults
  localparam logic [MsW-1:0] RstCurFadeOut  = MsW'(7500);
  localparam logic [MsW-1:0] RstCurDelay    = MsW'(2000);
  localparam logic [MsW-1:0] RstCurFadeIn   = MsW'(1000);
  localparam logic [MsW-1:0] RstDfltFadeOut = MsW'(1000);
  localparam logic [MsW-1:0] RstDfltDelay   = MsW'(2000);
  localparam logic [MsW-1:0] RstDfltFadeIn  = MsW'(7500);
  localparam logic [LevelW-1:0] RstMaxLevel  = LevelW'(65536);
  localparam logic [LevelW-1:0] RstSoftLevel = LevelW'(16384);

  // Bit positions in the default-in-use flags
  localparam int FlagOut   = 0;
  localparam int FlagDelay = 1;
  localparam int FlagIn    = 2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_PLAY = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_STOP = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_OUT  = 3'd0,
    CFG_DELAY     = 3'd1,
    CFG_FADE_IN   = 3'd2,
    CFG_MAX_LEVEL = 3'd3,
    CFG_SOFT_MAX  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                   kind;
    logic [TickW-1:0]       tick_ms;
    logic                   soft_mode;
    logic signed [ReqW-1:0] fade_out_req;
    logic signed [ReqW-1:0] delay_req;
    logic signed [ReqW-1:0] fade_in_req;
  } ded_cmd_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [1:0]        phase_out;
    logic              scene_running;
  } ded_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ded_div_stat_t;

endpackage

FILE: rtl/core/ded_if.sv
// Valid/ready channel interfaces for command and result items
interface ded_cmd_if import ded_pkg::*; ();
  logic     valid;
  logic     ready;
  ded_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ded_res_if import ded_pkg::*; ();
  logic     valid;
  logic     ready;
  ded_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ducking_envelope_controller_core.sv
// Ducking envelope controller: phase sequencer, state and output register
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    kind, tick_ms, soft_mode, three requests
//   res      out  valid/ready    level, phase_out, scene_running
//   cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// A stop item or a tick that needs no ramp step goes from idle to the push
// state; a ramping tick goes through the divide state, where the bit-serial
// divider forms floor(tick_ms * 65536 / fade), one quotient bit per cycle.
// One item is in work at a time; the next is taken while a result still
// waits in the output register. rst is synchronous and loads the reset values.
// A stalled result holds the sequencer before it loads the next result.
module ducking_envelope_controller_core import ded_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ded_cmd_if.sink              cmd,
  ded_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

  state_t state;

  // Configuration registers
  logic [MsW-1:0]    dflt_fade_out;
  logic [MsW-1:0]    dflt_delay;
  logic [MsW-1:0]    dflt_fade_in;
  logic [LevelW-1:0] max_lvl;
  logic [LevelW-1:0] soft_lvl;

  // Envelope state
  phase_t            phase;
  logic [TimeW-1:0]  phase_time;
  logic [LevelW-1:0] level;
  logic [MsW-1:0]    cur_fade_out;
  logic [MsW-1:0]    cur_delay;
  logic [MsW-1:0]    cur_fade_in;
  logic [2:0]        dflt_flags;
  logic              scene_on;
  logic              ramp_up;

  // Output register
  logic              res_valid;
  ded_out_t          res_data;

  logic              accept;
  logic [LevelW-1:0] target;
  logic [TimeW:0]    time_sum;
  logic [TimeW-1:0]  time_add;
  logic              need_div;
  logic [MsW-1:0]    fade_sel;
  logic [MsW-1:0]    div_den;
  ded_div_stat_t     div_stat;
  logic [QuotW-1:0]  quot;
  logic [QuotW:0]    up_sum;
  logic [LevelW-1:0] up_lvl;
  logic [LevelW-1:0] dn_lvl;
  logic [MsW-1:0]    new_fade_out;
  logic [MsW-1:0]    new_delay;
  logic [MsW-1:0]    new_fade_in;

  // Pick request or default, min-combine with a pending request, floor fades
  function automatic logic [MsW-1:0] combine(logic [ReqW-1:0] req,
                                             logic [MsW-1:0] dflt,
                                             logic [MsW-1:0] cur,
                                             logic is_dflt,
                                             logic floor1);
    logic [MsW-1:0] v;
    v = req[ReqW-1] ? dflt : req[MsW-1:0];
    if (!is_dflt && (cur < v)) v = cur;
    if (floor1 && (v == '0)) v = MsW'(1);
    return v;
  endfunction

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  // Target, saturating timer and ramp decision for the incoming tick
  always_comb begin
    target   = cmd.data.soft_mode ? soft_lvl : max_lvl;
    time_sum = {1'b0, phase_time} + (TimeW + 1)'(cmd.data.tick_ms);
    time_add = time_sum[TimeW] ? TimeMax : time_sum[TimeW-1:0];
    need_div = (cmd.data.kind == KIND_TICK) && scene_on &&
               (((phase == PH_PLAY) && (level != target)) ||
                ((phase == PH_STOP) && (level != '0)));
    fade_sel = (phase == PH_PLAY) ? cur_fade_in : cur_fade_out;
    div_den  = (fade_sel == '0) ? MsW'(1) : fade_sel;
  end

  // Stop request times
  always_comb begin
    new_fade_out = combine(cmd.data.fade_out_req, dflt_fade_out, cur_fade_out,
                           dflt_flags[FlagOut], 1'b1);
    new_delay    = combine(cmd.data.delay_req, dflt_delay, cur_delay,
                           dflt_flags[FlagDelay], 1'b0);
    new_fade_in  = combine(cmd.data.fade_in_req, dflt_fade_in, cur_fade_in,
                           dflt_flags[FlagIn], 1'b1);
  end

  ded_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && need_div),
    .dividend ({cmd.data.tick_ms, FracW'(0)}),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Apply the step: clamp at full going up, at zero going down
  always_comb begin
    up_sum = (QuotW + 1)'(level) + (QuotW + 1)'(quot);
    up_lvl = (up_sum > (QuotW + 1)'(FullLevel)) ? FullLevel : up_sum[LevelW-1:0];
    dn_lvl = (quot >= QuotW'(level)) ? '0 : (level - quot[LevelW-1:0]);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_fade_out <= RstDfltFadeOut;
      dflt_delay    <= RstDfltDelay;
      dflt_fade_in  <= RstDfltFadeIn;
      max_lvl       <= RstMaxLevel;
      soft_lvl      <= RstSoftLevel;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_OUT:  dflt_fade_out <= cfg_data[MsW-1:0];
        CFG_DELAY:     dflt_delay    <= cfg_data[MsW-1:0];
        CFG_FADE_IN:   dflt_fade_in  <= cfg_data[MsW-1:0];
        CFG_MAX_LEVEL: max_lvl       <= cfg_data[LevelW-1:0];
        CFG_SOFT_MAX:  soft_lvl      <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, envelope state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_WAIT;
      phase_time   <= '0;
      level        <= '0;
      cur_fade_out <= RstCurFadeOut;
      cur_delay    <= RstCurDelay;
      cur_fade_in  <= RstCurFadeIn;
      dflt_flags   <= '1;
      scene_on     <= 1'b0;
      ramp_up      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      // drop a taken result; the push state reloads the register itself
      if (res_valid && res.ready && (state != S_PUSH)) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.data.kind == KIND_STOP) begin
              cur_fade_out <= new_fade_out;
              cur_delay    <= new_delay;
              cur_fade_in  <= new_fade_in;
              dflt_flags   <= '0;
              phase        <= PH_STOP;
              phase_time   <= '0;
            end else begin
              unique case (phase)
                PH_WAIT: begin
                  if (phase_time > {1'b0, cur_delay}) begin
                    scene_on              <= 1'b1;
                    cur_delay             <= dflt_delay;
                    dflt_flags[FlagDelay] <= 1'b1;
                    level                 <= '0;
                    phase                 <= PH_PLAY;
                    phase_time            <= '0;
                  end else begin
                    phase_time <= time_add;
                  end
                end
                PH_PLAY: begin
                  if (!scene_on) begin
                    phase      <= PH_WAIT;
                    phase_time <= '0;
                  end else begin
                    if (level == target) begin
                      cur_fade_in        <= dflt_fade_in;
                      dflt_flags[FlagIn] <= 1'b1;
                    end
                    ramp_up    <= (level < target);
                    phase_time <= time_add;
                  end
                end
                PH_STOP: begin
                  if (scene_on && (level != '0)) begin
                    ramp_up    <= 1'b0;
                    phase_time <= time_add;
                  end else begin
                    if (scene_on) begin
                      cur_fade_out        <= dflt_fade_out;
                      dflt_flags[FlagOut] <= 1'b1;
                      scene_on            <= 1'b0;
                    end
                    phase      <= PH_WAIT;
                    phase_time <= TimeW'(cmd.data.tick_ms);
                  end
                end
                default: ;
              endcase
            end
            state <= need_div ? S_DIV : S_PUSH;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            level <= ramp_up ? up_lvl : dn_lvl;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold until the output register is free
          if (!res_valid || res.ready) begin
            res_valid              <= 1'b1;
            res_data.level         <= level;
            res_data.phase_out     <= phase;
            res_data.scene_running <= scene_on;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

FILE: rtl/core/ded_div.sv
// Bit-serial restoring divider for the ramp step, one quotient bit per cycle
module ded_div import ded_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [QuotW-1:0]   dividend,
  input  logic [MsW-1:0]     divisor,
  output ded_div_stat_t      stat,
  output logic [QuotW-1:0]   quotient
);

  logic [QuotW-1:0]   q;
  logic [MsW-1:0]     rem;
  logic [MsW-1:0]     den;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               done;

  logic [MsW:0] rem_sh;
  logic [MsW:0] diff;
  logic         ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, q[QuotW-1]};
    diff   = rem_sh - {1'b0, den};
    ge     = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        rem  <= '0;
        den  <= divisor;
        cnt  <= DivCntW'(QuotW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[QuotW-2:0], ge};
        rem <= ge ? diff[MsW-1:0] : rem_sh[MsW-1:0];
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - DivCntW'(1);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

FILE: rtl/core/ded_chk.sv
// Port-level checker for the ducking envelope controller, bound to the top
`include "ducking_envelope_controller_core_assert.svh"

module ded_chk import ded_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_ready,
  input logic     res_valid,
  input logic     res_ready,
  input ded_out_t res_data
);

  // A stalled result stays offered
  `DED_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

  // After an item is taken the block is busy in the cycle after
  `DED_ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "item taken back to back")

  // Level never rises above full scale
  `DED_ASSERT_IMP(a_level_range, res_valid, res_data.level <= FullLevel, "level above full scale")

  // Waiting means the scene is off and the level is down
  `DED_ASSERT_IMP(a_wait_quiet, res_valid && (res_data.phase_out == PH_WAIT), !res_data.scene_running && (res_data.level == '0), "waiting with scene or level")

  // Playing always runs the scene
  `DED_ASSERT_IMP(a_play_scene, res_valid && (res_data.phase_out == PH_PLAY), res_data.scene_running, "playing without scene")

endmodule

bind ducking_envelope_controller_core ded_chk u_ded_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the ducking envelope controller: directed and random items checked by a predictor
module tb;
  import ded_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 400;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  ded_cmd_if cmd ();
  ded_res_if res ();

  ducking_envelope_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and envelope state of the predictor
  logic [MsW-1:0]    reg_fout, reg_delay, reg_fin;
  logic [LevelW-1:0] reg_max, reg_soft;
  phase_t            env_phase;
  logic [TimeW-1:0]  env_time;
  logic [LevelW-1:0] env_level;
  logic [MsW-1:0]    env_fout, env_delay, env_fin;
  logic [2:0]        env_dflt;
  logic              env_scene;

  // Item stores and bookkeeping
  ded_cmd_t cmd_backlog[$];
  ded_out_t env_expected[$];
  int       cmd_issued = 0;
  int       cmd_accepted = 0;
  int       err_count = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     cmd_took = 1'b0;
  logic     hold_req = 1'b0;
  logic     hold_ack = 1'b0;
  int       rx_hold_left = 0;

  // Ramp step: floor(tick * 65536 / fade), zero fade counts as one
  function automatic logic [QuotW-1:0] ramp_step(logic [TickW-1:0] t, logic [MsW-1:0] fade);
    logic [QuotW-1:0] num;
    logic [QuotW-1:0] den;
    num = {t, FracW'(0)};
    den = (fade == '0) ? QuotW'(1) : QuotW'(fade);
    return num / den;
  endfunction

  // Saturating timer advance
  function automatic logic [TimeW-1:0] time_add(logic [TimeW-1:0] t, logic [TickW-1:0] d);
    logic [TimeW:0] s;
    s = {1'b0, t} + (TimeW + 1)'(d);
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  // Take the request or the default, then keep the smaller of an earlier request
  function automatic logic [MsW-1:0] pick_time(logic signed [ReqW-1:0] req,
                                               logic [MsW-1:0] dflt, logic [MsW-1:0] cur,
                                               logic in_default);
    logic [MsW-1:0] v;
    v = req[ReqW-1] ? dflt : req[MsW-1:0];
    if (!in_default && cur < v) v = cur;
    return v;
  endfunction

  // Advance the envelope by one item and return the result it yields
  function automatic ded_out_t envelope_predict(ded_cmd_t c);
    logic [LevelW-1:0] target;
    logic [QuotW-1:0]  step;
    logic [QuotW:0]    sum;
    ded_out_t          o;
    if (c.kind == KIND_STOP) begin
      env_fout = pick_time(c.fade_out_req, reg_fout, env_fout, env_dflt[FlagOut]);
      if (env_fout == '0) env_fout = MsW'(1);
      env_delay = pick_time(c.delay_req, reg_delay, env_delay, env_dflt[FlagDelay]);
      env_fin = pick_time(c.fade_in_req, reg_fin, env_fin, env_dflt[FlagIn]);
      if (env_fin == '0) env_fin = MsW'(1);
      env_dflt = '0;
      env_phase = PH_STOP;
      env_time = '0;
    end else begin
      target = c.soft_mode ? reg_soft : reg_max;
      case (env_phase)
        PH_WAIT: begin
          if (env_time > env_delay) begin
            env_scene = 1'b1;
            env_delay = reg_delay;
            env_dflt[FlagDelay] = 1'b1;
            env_level = '0;
            env_phase = PH_PLAY;
            env_time = '0;
          end else begin
            env_time = time_add(env_time, c.tick_ms);
          end
        end
        PH_PLAY: begin
          if (!env_scene) begin
            env_phase = PH_WAIT;
            env_time = '0;
          end else begin
            step = ramp_step(c.tick_ms, env_fin);
            if (env_level < target) begin
              sum = (QuotW + 1)'(env_level) + (QuotW + 1)'(step);
              env_level = (sum > (QuotW + 1)'(FullLevel)) ? FullLevel : sum[LevelW-1:0];
            end else if (env_level > target) begin
              env_level = (env_level > step) ? env_level - step[LevelW-1:0] : '0;
            end else begin
              env_fin = reg_fin;
              env_dflt[FlagIn] = 1'b1;
            end
            env_time = time_add(env_time, c.tick_ms);
          end
        end
        PH_STOP: begin
          if (env_scene && env_level != '0) begin
            step = ramp_step(c.tick_ms, env_fout);
            env_level = (env_level > step) ? env_level - step[LevelW-1:0] : '0;
            env_time = time_add(env_time, c.tick_ms);
          end else begin
            if (env_scene) begin
              env_fout = reg_fout;
              env_dflt[FlagOut] = 1'b1;
              env_scene = 1'b0;
            end
            env_phase = PH_WAIT;
            env_time = time_add('0, c.tick_ms);
          end
        end
        default: ;
      endcase
    end
    o.level = env_level;
    o.phase_out = env_phase;
    o.scene_running = env_scene;
    return o;
  endfunction

  // Item builders; unused fields carry random bits
  function automatic ded_cmd_t make_tick(logic [TickW-1:0] t, logic soft_sel);
    ded_cmd_t c;
    c.kind = KIND_TICK;
    c.tick_ms = t;
    c.soft_mode = soft_sel;
    c.fade_out_req = ReqW'($urandom);
    c.delay_req = ReqW'($urandom);
    c.fade_in_req = ReqW'($urandom);
    return c;
  endfunction

  function automatic ded_cmd_t make_stop(logic signed [ReqW-1:0] fo,
                                         logic signed [ReqW-1:0] dl,
                                         logic signed [ReqW-1:0] fi);
    ded_cmd_t c;
    c.kind = KIND_STOP;
    c.tick_ms = TickW'($urandom);
    c.soft_mode = 1'($urandom_range(1));
    c.fade_out_req = fo;
    c.delay_req = dl;
    c.fade_in_req = fi;
    return c;
  endfunction

  function automatic logic [TickW-1:0] rand_tick();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return TickW'($urandom_range(255));
  endfunction

  // Mostly default or short times, with odd negatives and raw bit patterns
  function automatic logic signed [ReqW-1:0] rand_req();
    int r;
    r = $urandom_range(99);
    if (r < 35) return -1;
    if (r < 43) return ReqW'($urandom_range(16'hFFFE, 16'h8000));
    if (r < 50) return ReqW'($urandom);
    if (r < 58) return 0;
    if (r < 62) return 24000;
    if (r < 64) return 32767;
    return ReqW'($urandom_range(600, 1));
  endfunction

  task automatic queue_item(ded_cmd_t c);
    cmd_backlog.push_back(c);
    cmd_issued++;
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 7) queue_item(make_stop(rand_req(), rand_req(), rand_req()));
      else queue_item(make_tick(rand_tick(), $urandom_range(99) < 30));
    end
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FADE_OUT:  reg_fout = val[MsW-1:0];
      CFG_DELAY:     reg_delay = val[MsW-1:0];
      CFG_FADE_IN:   reg_fin = val[MsW-1:0];
      CFG_MAX_LEVEL: reg_max = val[LevelW-1:0];
      CFG_SOFT_MAX:  reg_soft = val[LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int fout, int dly, int fin, int maxl, int softl);
    write_reg(CFG_FADE_OUT, CfgW'(fout));
    write_reg(CFG_DELAY, CfgW'(dly));
    write_reg(CFG_FADE_IN, CfgW'(fin));
    write_reg(CFG_MAX_LEVEL, CfgW'(maxl));
    write_reg(CFG_SOFT_MAX, CfgW'(softl));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk); while (cmd_accepted != cmd_issued || env_expected.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("tb: mismatch on %s, got %0d, want %0d, at %0t", what, got, want, $realtime);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cap the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Drive command items, holding each until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (cmd.valid && !cmd_took) begin
        // hold the current item
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cmd.data <= cmd_backlog.pop_front();
        cmd.valid <= 1'b1;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      rx_hold_left <= HoldCycles;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Accept results at random, never during a hold-off
  always @(negedge clk) begin
    if (!rst) res.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  // Predict on each taken item, check each delivered result
  always @(posedge clk) begin
    ded_out_t want;
    if (rst) begin
      cmd_took <= 1'b0;
    end else begin
      cmd_took <= cmd.valid && cmd.ready;
      if (cmd.valid && cmd.ready) begin
        env_expected.push_back(envelope_predict(cmd.data));
        cmd_accepted++;
      end
      if (res.valid && res.ready) begin
        if (env_expected.size() == 0) begin
          flag_mismatch("result with nothing expected", 32'(res.data.level), 0);
        end else begin
          want = env_expected.pop_front();
          if (res.data.level !== want.level)
            flag_mismatch("level", 32'(res.data.level), 32'(want.level));
          if (res.data.phase_out !== want.phase_out)
            flag_mismatch("phase_out", 32'(res.data.phase_out), 32'(want.phase_out));
          if (res.data.scene_running !== want.scene_running)
            flag_mismatch("scene_running", 32'(res.data.scene_running),
                          32'(want.scene_running));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.data = '0;
    res.ready = 1'b0;
    reg_fout = RstDfltFadeOut;
    reg_delay = RstDfltDelay;
    reg_fin = RstDfltFadeIn;
    reg_max = RstMaxLevel;
    reg_soft = RstSoftLevel;
    env_phase = PH_WAIT;
    env_time = '0;
    env_level = '0;
    env_fout = RstCurFadeOut;
    env_delay = RstCurDelay;
    env_fin = RstCurFadeIn;
    env_dflt = 3'b111;
    env_scene = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: shortest times, full and zero targets
    tx_idle_pct = 9;
    rx_idle_pct = 60;
    configure(1, 0, 1, 65536, 0);
    queue_item(make_tick(0, 0));
    queue_item(make_tick(1, 0));
    queue_item(make_tick(255, 1));
    queue_item(make_tick(255, 0));
    queue_item(make_tick(0, 0));
    queue_item(make_tick(1, 1));
    queue_item(make_tick(0, 1));
    queue_item(make_tick(128, 0));
    queue_item(make_stop(24000, 24000, 24000));
    queue_item(make_tick(255, 0));
    queue_item(make_stop(-1, -1, -1));
    queue_item(make_stop(0, -32768, 0));
    queue_item(make_tick(0, 0));
    queue_item(make_tick(255, 0));
    queue_item(make_tick(7, 0));
    queue_item(make_stop(32767, 32767, 32767));
    queue_item(make_tick(3, 1));
    queue_item(make_tick(0, 0));
    queue_item(make_tick(200, 0));
    queue_item(make_tick(255, 1));
    queue_item(make_stop(5, 1, 2));
    queue_item(make_tick(9, 0));
    queue_item(make_tick(255, 0));
    wait_idle();

    // Typical times; one long run of large ticks pins the timer
    configure(300, 400, 2000, 65536, 16384);
    for (int i = 0; i < 280; i++)
      queue_item(make_tick(TickW'($urandom_range(255, 200)), 1'((i / 40) % 2)));
    queue_random(110);
    wait_idle();

    // Long fades, target above full; swap the idle rates
    tx_idle_pct = 60;
    rx_idle_pct = 9;
    configure(32767, 150, 32767, 131071, 65536);
    queue_random(110);
    wait_idle();

    // Zero fades and zero target, no idling, receiver held off at the start
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(0, 32767, 0, 0, 40000);
    hold_req = ~hold_req;
    queue_random(110);
    wait_idle();

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
